// File: sv/bmf_pkg.sv
// Package for the clipped 5x5 box mean filter: field widths, register and command codes,
// and the reciprocal table used by the mean divider.
// No dependencies.
package bmf_pkg;

  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int WINDOW_RADIUS_DEF = 2;

  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int ROWCNT_W   = 17;
  localparam int MEAN_W     = 16;
  localparam int OUT_ROW_W  = 16;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

  // divide by pixel count: q = floor(num * floor(2^DIV_SHIFT / cnt) / 2^DIV_SHIFT) + fix
  localparam int DIV_SHIFT   = 22;
  localparam int NUM_W       = DIV_SHIFT;
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam int CNT_W       = 6;
  localparam int RECIP_DEPTH = 50;
  localparam int RECIP_ONE   = 2 ** DIV_SHIFT;

  localparam logic [RECIP_W-1:0] RECIP_LUT [RECIP_DEPTH] = '{
    23'd0,                  23'(RECIP_ONE / 1),  23'(RECIP_ONE / 2),  23'(RECIP_ONE / 3),
    23'(RECIP_ONE / 4),     23'(RECIP_ONE / 5),  23'(RECIP_ONE / 6),  23'(RECIP_ONE / 7),
    23'(RECIP_ONE / 8),     23'(RECIP_ONE / 9),  23'(RECIP_ONE / 10), 23'(RECIP_ONE / 11),
    23'(RECIP_ONE / 12),    23'(RECIP_ONE / 13), 23'(RECIP_ONE / 14), 23'(RECIP_ONE / 15),
    23'(RECIP_ONE / 16),    23'(RECIP_ONE / 17), 23'(RECIP_ONE / 18), 23'(RECIP_ONE / 19),
    23'(RECIP_ONE / 20),    23'(RECIP_ONE / 21), 23'(RECIP_ONE / 22), 23'(RECIP_ONE / 23),
    23'(RECIP_ONE / 24),    23'(RECIP_ONE / 25), 23'(RECIP_ONE / 26), 23'(RECIP_ONE / 27),
    23'(RECIP_ONE / 28),    23'(RECIP_ONE / 29), 23'(RECIP_ONE / 30), 23'(RECIP_ONE / 31),
    23'(RECIP_ONE / 32),    23'(RECIP_ONE / 33), 23'(RECIP_ONE / 34), 23'(RECIP_ONE / 35),
    23'(RECIP_ONE / 36),    23'(RECIP_ONE / 37), 23'(RECIP_ONE / 38), 23'(RECIP_ONE / 39),
    23'(RECIP_ONE / 40),    23'(RECIP_ONE / 41), 23'(RECIP_ONE / 42), 23'(RECIP_ONE / 43),
    23'(RECIP_ONE / 44),    23'(RECIP_ONE / 45), 23'(RECIP_ONE / 46), 23'(RECIP_ONE / 47),
    23'(RECIP_ONE / 48),    23'(RECIP_ONE / 49)
  };

endpackage

// File: sv/box_mean_filter_5x5_core.sv
// Clipped box mean filter, top level: column store, column-sum taps, divider and output register.
// Depends on bmf_pkg.
//
// Pixels enter in raster order; each item reads the column word (all ring rows of one column side
// by side) from the column store and writes it back with its pixel merged while its row lies
// inside the image, but a drain item arriving before frame end is dropped without a store access.
// Each result passes the window sum, reciprocal multiply and remainder fix steps, after shift
// steps that pad a narrow image's row end, and waits in the fix step while the output
// register holds a result under out_stall_i. Results lag input by WINDOW_RADIUS rows and
// columns; WINDOW_RADIUS * width drain items (cmd 1) flush the last rows. Writing the width or
// height register restarts the frame. The column store is not cleared after reset; only pixels
// of the current frame are read.
module box_mean_filter_5x5_core #(
  parameter int MAX_WIDTH     = bmf_pkg::MAX_WIDTH_DEF,
  parameter int WINDOW_RADIUS = bmf_pkg::WINDOW_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [bmf_pkg::PIX_W-1:0]       pixel_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bmf_pkg::MEAN_W-1:0]      mean_value_o,
  output logic [bmf_pkg::OUT_ROW_W-1:0]   out_row_o,
  output logic [bmf_pkg::OUT_COL_W-1:0]   out_col_o,
  output logic                            last_of_run_o,
  output logic                            frame_done_o
);

  localparam int RING     = 2 * WINDOW_RADIUS + 1;
  localparam int SLOT_W   = $clog2(RING);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int MEM_W    = RING * bmf_pkg::PIX_W;
  localparam int COLSUM_W = bmf_pkg::PIX_W + $clog2(RING);
  localparam int WINSUM_W = COLSUM_W + $clog2(RING);
  localparam int NCNT_W   = $clog2(RING + 1);
  localparam int SKIP_W   = $clog2(WINDOW_RADIUS + 1);
  localparam int RW       = bmf_pkg::ROWCNT_W;
  localparam int NUM_W    = bmf_pkg::NUM_W;
  localparam int CNT_W    = bmf_pkg::CNT_W;
  localparam int MEAN_W   = bmf_pkg::MEAN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COL  = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;

  logic [2:0]                      state_q, state_d;
  logic [bmf_pkg::IMG_W_W-1:0]     width_q, width_d;
  logic [bmf_pkg::IMG_H_W-1:0]     height_q, height_d;
  logic [RW-1:0]                   row_q, row_d;
  logic [CW-1:0]                   col_q, col_d;
  logic [SLOT_W-1:0]               slot_q, slot_d;

  logic [bmf_pkg::PIX_W-1:0]       pix_q, pix_d;
  logic                            store_q, store_d;
  logic [CW-1:0]                   cc_q, cc_d;
  logic [CW-1:0]                   last_q, last_d;
  logic [SKIP_W-1:0]               skip_q, skip_d;
  logic [bmf_pkg::OUT_ROW_W-1:0]   cr_q, cr_d;
  logic [NCNT_W-1:0]               rows_q, rows_d;
  logic [NUM_W-1:0]                num_q, num_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [MEAN_W-1:0]               q0_q, q0_d;

  logic [COLSUM_W-1:0]             tap_q [RING];
  logic [COLSUM_W-1:0]             tap_d [RING];
  logic [RING-1:0]                 tap_vld_q, tap_vld_d;

  logic                            out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]               mean_q, mean_d;
  logic [bmf_pkg::OUT_ROW_W-1:0]   orow_q, orow_d;
  logic [CW-1:0]                   ocol_q, ocol_d;
  logic                            olast_q, olast_d;
  logic                            odone_q, odone_d;

  logic [MEM_W-1:0]                line_mem [MAX_WIDTH];
  logic [MEM_W-1:0]                mem_rdata_q;
  logic [MEM_W-1:0]                mem_wdata;
  logic                            mem_re, mem_we;

  logic [WW-1:0]                   w_eff;
  logic [bmf_pkg::IMG_H_W-1:0]     h_eff;
  logic [RING-1:0]                 row_vld;
  logic [COLSUM_W-1:0]             col_sum;
  logic [WINSUM_W-1:0]             win_sum;
  logic [2*NUM_W+1:0]              recip_prod;
  logic [NUM_W-1:0]                q0_cnt;
  logic [NUM_W-1:0]                rem;
  logic                            out_load;
  logic                            in_take;
  logic                            cfg_take;
  logic                            col_last;
  logic                            emit;

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_stall_o    = (state_q != S_IDLE) || cfg_valid_i;
  assign in_take       = in_valid_i && !in_stall_o;
  assign cfg_take      = cfg_valid_i && cfg_ready_o;

  assign out_valid_o   = out_valid_q;
  assign mean_value_o  = mean_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = bmf_pkg::OUT_COL_W'(ocol_q);
  assign last_of_run_o = olast_q;
  assign frame_done_o  = odone_q;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    h_eff = (height_q == '0) ? bmf_pkg::IMG_H_W'(1) : height_q;
  end

  // column word with this item's pixel merged, and its sum over rows inside the image
  always_comb begin
    mem_wdata = mem_rdata_q;
    if (store_q) begin
      mem_wdata[slot_q*bmf_pkg::PIX_W +: bmf_pkg::PIX_W] = pix_q;
    end
    col_sum = '0;
    for (int k = 0; k < RING; k++) begin
      automatic int j = int'(slot_q) - k;
      if (j < 0) begin
        j = j + RING;
      end
      row_vld[k] = ({1'b0, row_q} >= (RW + 1)'(k)) &&
                   ({1'b0, row_q} < (RW + 1)'(h_eff) + (RW + 1)'(k));
      if (row_vld[k]) begin
        col_sum = col_sum + COLSUM_W'(mem_wdata[j*bmf_pkg::PIX_W +: bmf_pkg::PIX_W]);
      end
    end
  end

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < RING; i++) begin
      win_sum = win_sum + WINSUM_W'(tap_q[i]);
    end
  end

  assign recip_prod = (2 * NUM_W + 2)'(num_q) * (2 * NUM_W + 2)'(bmf_pkg::RECIP_LUT[cnt_q]);
  assign q0_cnt     = NUM_W'(q0_q) * NUM_W'(cnt_q);
  assign rem        = num_q - q0_cnt;
  assign col_last   = (WW'(col_q) + WW'(1)) == w_eff;
  assign emit       = (row_q >= RW'(WINDOW_RADIUS)) && ((col_q >= CW'(WINDOW_RADIUS)) || col_last);

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    row_d       = row_q;
    col_d       = col_q;
    slot_d      = slot_q;
    pix_d       = pix_q;
    store_d     = store_q;
    cc_d        = cc_q;
    last_d      = last_q;
    skip_d      = skip_q;
    cr_d        = cr_q;
    rows_d      = rows_q;
    num_d       = num_q;
    cnt_d       = cnt_q;
    q0_d        = q0_q;
    tap_d       = tap_q;
    tap_vld_d   = tap_vld_q;
    mean_d      = mean_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    olast_d     = olast_q;
    odone_d     = odone_q;
    out_load    = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_take) begin
          unique case (cfg_index_i)
            bmf_pkg::REG_IMAGE_WIDTH: begin
              width_d = cfg_data_i[bmf_pkg::IMG_W_W-1:0];
              row_d   = '0;
              col_d   = '0;
              slot_d  = '0;
            end
            bmf_pkg::REG_IMAGE_HEIGHT: begin
              height_d = cfg_data_i;
              row_d    = '0;
              col_d    = '0;
              slot_d   = '0;
            end
            default: begin
            end
          endcase
        end else if (in_take) begin
          store_d = (row_q < RW'(h_eff));
          pix_d   = pixel_i;
          if (!(store_d && cmd_i == bmf_pkg::CMD_DRAIN)) begin
            mem_re  = 1'b1;
            state_d = S_COL;
          end
        end
      end

      S_COL: begin
        mem_we = store_q;
        if (col_q == '0) begin
          for (int i = 1; i < RING; i++) begin
            tap_d[i] = '0;
          end
          tap_vld_d = RING'(1);
        end else begin
          for (int i = 1; i < RING; i++) begin
            tap_d[i] = tap_q[i-1];
          end
          tap_vld_d = {tap_vld_q[RING-2:0], 1'b1};
        end
        tap_d[0] = col_sum;
        rows_d   = NCNT_W'($countones(row_vld));
        cr_d     = bmf_pkg::OUT_ROW_W'(row_q - RW'(WINDOW_RADIUS));
        if (col_q >= CW'(WINDOW_RADIUS)) begin
          cc_d   = col_q - CW'(WINDOW_RADIUS);
          skip_d = '0;
        end else begin
          cc_d   = '0;
          skip_d = SKIP_W'(WINDOW_RADIUS) - SKIP_W'(col_q);
        end
        last_d = col_last ? col_q : cc_d;

        if (col_last) begin
          col_d = '0;
          if ({1'b0, row_q} + (RW + 1)'(1) >=
              (RW + 1)'(h_eff) + (RW + 1)'(WINDOW_RADIUS)) begin
            row_d  = '0;
            slot_d = '0;
          end else begin
            row_d  = row_q + RW'(1);
            slot_d = (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end

        if (!emit) begin
          state_d = S_IDLE;
        end else if (skip_d != '0) begin
          state_d = S_SKIP;
        end else begin
          state_d = S_SUM;
        end
      end

      S_SKIP: begin
        for (int i = 1; i < RING; i++) begin
          tap_d[i] = tap_q[i-1];
        end
        tap_d[0]  = '0;
        tap_vld_d = {tap_vld_q[RING-2:0], 1'b0};
        skip_d    = skip_q - SKIP_W'(1);
        if (skip_q == SKIP_W'(1)) begin
          state_d = S_SUM;
        end
      end

      S_SUM: begin
        num_d   = NUM_W'({win_sum, 8'd0});
        cnt_d   = CNT_W'(rows_q) * CNT_W'($countones(tap_vld_q));
        state_d = S_MUL;
      end

      S_MUL: begin
        q0_d    = recip_prod[bmf_pkg::DIV_SHIFT +: MEAN_W];
        state_d = S_FIX;
      end

      S_FIX: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          mean_d   = (rem >= NUM_W'(cnt_q)) ? q0_q + MEAN_W'(1) : q0_q;
          orow_d   = cr_q;
          ocol_d   = cc_q;
          olast_d  = (cc_q == last_q);
          odone_d  = (cr_q == h_eff - bmf_pkg::IMG_H_W'(1)) &&
                     (WW'(cc_q) == w_eff - WW'(1));
          if (cc_q == last_q) begin
            state_d = S_IDLE;
          end else begin
            for (int i = 1; i < RING; i++) begin
              tap_d[i] = tap_q[i-1];
            end
            tap_d[0]  = '0;
            tap_vld_d = {tap_vld_q[RING-2:0], 1'b0};
            cc_d      = cc_q + CW'(1);
            state_d   = S_SUM;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= bmf_pkg::IMAGE_WIDTH_RST;
      height_q    <= bmf_pkg::IMAGE_HEIGHT_RST;
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      tap_vld_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RING; i++) begin
        tap_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      row_q       <= row_d;
      col_q       <= col_d;
      slot_q      <= slot_d;
      tap_vld_q   <= tap_vld_d;
      out_valid_q <= out_valid_d;
      tap_q       <= tap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q   <= pix_d;
    store_q <= store_d;
    cc_q    <= cc_d;
    last_q  <= last_d;
    skip_q  <= skip_d;
    cr_q    <= cr_d;
    rows_q  <= rows_d;
    num_q   <= num_d;
    cnt_q   <= cnt_d;
    q0_q    <= q0_d;
    mean_q  <= mean_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
    odone_q <= odone_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_q] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= line_mem[col_q];
    end
  end

`ifndef SYNTHESIS
  a_mem_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("column store read and write in the same cycle");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> cnt_q != '0)
    else $error("window pixel count is zero");

  a_div_fix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIX |-> rem < NUM_W'({cnt_q, 1'b0}))
    else $error("reciprocal estimate off by more than one");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("held result overwritten");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> WW'(col_q) < w_eff)
    else $error("column counter beyond image width");
`endif

endmodule
